### hdl/sapg_pkg.sv
// ----------------------------------------------------------------------------
// sapg_pkg
// Shared types, widths and constants of the spatial audio pan/gain pipeline.
// ----------------------------------------------------------------------------
package sapg_pkg;

  // Fixed-point widths of the datapath
  localparam int SqW    = 34;  // squared length of a 3-vector
  localparam int LenSh  = 16;  // squared length is scaled by 2^16 before the root
  localparam int RadW   = 50;  // root operand: SqW + LenSh
  localparam int RootW  = 25;  // floor square root of RadW bits
  localparam int DotW   = 35;  // signed dot product
  localparam int MagW   = 34;  // dot product magnitude
  localparam int DenW   = 50;  // product of two roots
  localparam int NumW   = 64;  // scaled dividend
  localparam int QuoW   = 16;  // quotient: 16384 * cosine
  localparam int CosSh  = 30;  // dividend scale

  localparam logic [15:0] OneQ15  = 16'h8000;
  localparam logic [15:0] HalfQ15 = 16'h4000;

  typedef enum logic [0:0] {
    REG_MAX_LEVEL = 1'b0,
    REG_MIN_LEVEL = 1'b1
  } sapg_reg_e;

  typedef struct packed {
    logic signed [15:0] listener_x;
    logic signed [15:0] listener_y;
    logic signed [15:0] listener_z;
    logic signed [15:0] source_x;
    logic signed [15:0] source_y;
    logic signed [15:0] source_z;
    logic signed [15:0] ear_dir_x;
    logic signed [15:0] ear_dir_y;
    logic signed [15:0] ear_dir_z;
    logic signed [15:0] emit_dir_x;
    logic signed [15:0] emit_dir_y;
    logic signed [15:0] emit_dir_z;
  } sapg_in_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] pan_value;
    logic [15:0] volume_value;
    logic        fault;
  } sapg_out_t;

  // Dot products and squared lengths out of the vector front end
  typedef struct packed {
    logic signed [DotW-1:0] dot_pan;
    logic signed [DotW-1:0] dot_dir;
    logic [SqW-1:0]         sq_e;
    logic [SqW-1:0]         sq_d;
    logic [SqW-1:0]         sq_m;
    logic                   fault;
  } sapg_vec_t;

endpackage

### hdl/sapg_vec.sv
// ----------------------------------------------------------------------------
// sapg_vec
// Vector front end: difference vector, component products, dot products and
// squared lengths in three register stages.
// ----------------------------------------------------------------------------
module sapg_vec import sapg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  sapg_in_t  data_i,
  output logic      valid_o,
  output sapg_vec_t data_o
);

  logic              v1_q, v2_q, v3_q;
  logic signed [16:0] d_q [3];
  logic signed [15:0] e_q [3];
  logic signed [15:0] m_q [3];
  logic signed [32:0] pd_q [3];
  logic signed [31:0] pm_q [3];
  logic [31:0]        sd_q [3];
  logic [31:0]        se_q [3];
  logic [31:0]        sm_q [3];
  sapg_vec_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // listener minus source
      d_q[0] <= 17'(data_i.listener_x) - 17'(data_i.source_x);
      d_q[1] <= 17'(data_i.listener_y) - 17'(data_i.source_y);
      d_q[2] <= 17'(data_i.listener_z) - 17'(data_i.source_z);
      e_q[0] <= data_i.ear_dir_x;
      e_q[1] <= data_i.ear_dir_y;
      e_q[2] <= data_i.ear_dir_z;
      m_q[0] <= data_i.emit_dir_x;
      m_q[1] <= data_i.emit_dir_y;
      m_q[2] <= data_i.emit_dir_z;
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= 33'(e_q[i]) * 33'(d_q[i]);
        pm_q[i] <= 32'(e_q[i]) * 32'(m_q[i]);
        sd_q[i] <= 32'(34'(d_q[i]) * 34'(d_q[i]));
        se_q[i] <= 32'(32'(e_q[i]) * 32'(e_q[i]));
        sm_q[i] <= 32'(32'(m_q[i]) * 32'(m_q[i]));
      end
      out_q.dot_pan <= DotW'(pd_q[0]) + DotW'(pd_q[1]) + DotW'(pd_q[2]);
      out_q.dot_dir <= DotW'(pm_q[0]) + DotW'(pm_q[1]) + DotW'(pm_q[2]);
      out_q.sq_e    <= SqW'(se_q[0]) + SqW'(se_q[1]) + SqW'(se_q[2]);
      out_q.sq_d    <= SqW'(sd_q[0]) + SqW'(sd_q[1]) + SqW'(sd_q[2]);
      out_q.sq_m    <= SqW'(sm_q[0]) + SqW'(sm_q[1]) + SqW'(sm_q[2]);
      out_q.fault   <= ((se_q[0] | se_q[1] | se_q[2]) == '0) ||
                       ((sd_q[0] | sd_q[1] | sd_q[2]) == '0) ||
                       ((sm_q[0] | sm_q[1] | sm_q[2]) == '0);
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule

### hdl/sapg_isqrt.sv
// ----------------------------------------------------------------------------
// sapg_isqrt
// Pipelined floor square root, one root bit per stage, several lanes in
// lockstep, with a sideband tag carried alongside.
// ----------------------------------------------------------------------------
module sapg_isqrt import sapg_pkg::*; #(
  parameter int LANES = 3,
  parameter int IN_W  = 50,
  parameter int OUT_W = 25,
  parameter int TAG_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][IN_W-1:0]  rad_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [LANES-1:0][OUT_W-1:0] root_o,
  output logic [TAG_W-1:0]            tag_o
);

  logic [LANES-1:0][IN_W-1:0]  rem  [OUT_W+1];
  logic [LANES-1:0][OUT_W-1:0] root [OUT_W+1];
  logic [TAG_W-1:0]            tag  [OUT_W+1];
  logic                        vld  [OUT_W+1];

  assign rem[0]  = rad_i;
  assign root[0] = '0;
  assign tag[0]  = tag_i;
  assign vld[0]  = valid_i;

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int B = OUT_W - 1 - k;
    logic [LANES-1:0][IN_W-1:0]  rem_d;
    logic [LANES-1:0][OUT_W-1:0] root_d;

    always_comb begin
      logic [IN_W:0] trial;
      for (int l = 0; l < LANES; l++) begin
        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        trial = (IN_W + 1)'(root[k][l]) << (B + 1);
        trial[2*B] = 1'b1;
        if ({1'b0, rem[k][l]} >= trial) begin
          rem_d[l]  = rem[k][l] - trial[IN_W-1:0];
          root_d[l] = root[k][l] | (OUT_W'(1) << B);
        end else begin
          rem_d[l]  = rem[k][l];
          root_d[l] = root[k][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1]  <= rem_d;
        root[k+1] <= root_d;
        tag[k+1]  <= tag[k];
      end
    end
  end

  assign valid_o = vld[OUT_W];
  assign root_o  = root[OUT_W];
  assign tag_o   = tag[OUT_W];

endmodule

### hdl/sapg_div.sv
// ----------------------------------------------------------------------------
// sapg_div
// Pipelined restoring divider, one quotient bit per stage, several lanes in
// lockstep. A quotient that does not fit saturates to all ones.
// ----------------------------------------------------------------------------
module sapg_div import sapg_pkg::*; #(
  parameter int LANES = 2,
  parameter int NUM_W = 64,
  parameter int DEN_W = 50,
  parameter int QUO_W = 16,
  parameter int TAG_W = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][NUM_W-1:0] num_i,
  input  logic [LANES-1:0][DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [LANES-1:0][QUO_W-1:0] quo_o,
  output logic [TAG_W-1:0]            tag_o
);

  localparam int RemW = DEN_W + QUO_W;

  logic [LANES-1:0][RemW-1:0]  rem [QUO_W+1];
  logic [LANES-1:0][DEN_W-1:0] den [QUO_W+1];
  logic [LANES-1:0][QUO_W-1:0] quo [QUO_W+1];
  logic [LANES-1:0]            ovf [QUO_W+1];
  logic [TAG_W-1:0]            tag [QUO_W+1];
  logic                        vld [QUO_W+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = RemW'(num_i[l]);
      ovf[0][l] = (RemW + 1)'(num_i[l]) >= ((RemW + 1)'(den_i[l]) << QUO_W);
    end
  end
  assign den[0] = den_i;
  assign quo[0] = '0;
  assign tag[0] = tag_i;
  assign vld[0] = valid_i;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [LANES-1:0][RemW-1:0]  rem_d;
    logic [LANES-1:0][QUO_W-1:0] quo_d;

    always_comb begin
      logic [RemW-1:0] dsh;
      for (int l = 0; l < LANES; l++) begin
        dsh = RemW'(den[k][l]) << B;
        if (rem[k][l] >= dsh) begin
          rem_d[l] = rem[k][l] - dsh;
          quo_d[l] = quo[k][l] | (QUO_W'(1) << B);
        end else begin
          rem_d[l] = rem[k][l];
          quo_d[l] = quo[k][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1] <= rem_d;
        den[k+1] <= den[k];
        quo[k+1] <= quo_d;
        ovf[k+1] <= ovf[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = ovf[QUO_W][l] ? '1 : quo[QUO_W][l];
    end
  end
  assign valid_o = vld[QUO_W];
  assign tag_o   = tag[QUO_W];

endmodule

### hdl/spatial_audio_pan_gain_top.sv
// ----------------------------------------------------------------------------
// spatial_audio_pan_gain_top
// Cosine panning with directivity blend: pan, volume and gain per voice.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless stalled and returns one result
// per item, in order. Depth is set by the square root unit (one root bit per
// stage, 25 stages), the divider (one quotient bit per stage, 16 stages), the
// front end and the blend stages. The pipe advances whenever the output
// register is empty or being taken, so a stall at the output holds every
// stage and loses nothing. max_level and min_level are read live; the user
// must write them only while no item is in flight; nothing here enforces it.
module spatial_audio_pan_gain_top import sapg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sapg_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sapg_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  typedef struct packed {
    logic signed [DotW-1:0] dot_pan;
    logic signed [DotW-1:0] dot_dir;
    logic                   fault;
  } sapg_sqtag_t;

  typedef struct packed {
    logic neg_pan;
    logic neg_dir;
    logic fault;
  } sapg_dvtag_t;

  function automatic logic [15:0] to_unit(logic neg, logic [QuoW-1:0] q);
    logic [15:0] v;
    if (neg) begin
      v = (q >= QuoW'(HalfQ15)) ? 16'd0 : HalfQ15 - 16'(q);
    end else begin
      v = (q >= QuoW'(HalfQ15)) ? OneQ15 : HalfQ15 + 16'(q);
    end
    return v;
  endfunction

  logic        en;
  logic [15:0] max_level_q, min_level_q;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= OneQ15;
      min_level_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (sapg_reg_e'(cfg_addr_i))
        REG_MAX_LEVEL: max_level_q <= cfg_wdata_i;
        REG_MIN_LEVEL: min_level_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Front end
  logic      vec_valid;
  sapg_vec_t vec;

  sapg_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (vec_valid),
    .data_o  (vec)
  );

  // Lengths: lane 0 ear facing, lane 1 difference, lane 2 emit facing
  logic [2:0][RadW-1:0]  rad;
  logic [2:0][RootW-1:0] root;
  logic                  sq_valid;
  sapg_sqtag_t           sq_tag_in, sq_tag;

  assign rad[0]    = {vec.sq_e, LenSh'(0)};
  assign rad[1]    = {vec.sq_d, LenSh'(0)};
  assign rad[2]    = {vec.sq_m, LenSh'(0)};
  assign sq_tag_in = '{dot_pan: vec.dot_pan, dot_dir: vec.dot_dir, fault: vec.fault};

  sapg_isqrt #(
    .LANES (3),
    .IN_W  (RadW),
    .OUT_W (RootW),
    .TAG_W ($bits(sapg_sqtag_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_valid),
    .rad_i   (rad),
    .tag_i   (sq_tag_in),
    .valid_o (sq_valid),
    .root_o  (root),
    .tag_o   (sq_tag)
  );

  // Denominators and dividends
  logic            t1_v_q, t2_v_q;
  logic [DenW-1:0] den_pan_q, den_dir_q;
  logic [MagW-1:0] mag_pan_q, mag_dir_q;
  sapg_dvtag_t     t1_tag_q, t2_tag_q;
  logic [1:0][NumW-1:0] num_q;
  logic [1:0][DenW-1:0] den2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_pan_q <= DenW'(root[0]) * DenW'(root[1]);
      den_dir_q <= DenW'(root[0]) * DenW'(root[2]);
      mag_pan_q <= MagW'(sq_tag.dot_pan < 0 ? -sq_tag.dot_pan : sq_tag.dot_pan);
      mag_dir_q <= MagW'(sq_tag.dot_dir < 0 ? -sq_tag.dot_dir : sq_tag.dot_dir);
      t1_tag_q  <= '{neg_pan: sq_tag.dot_pan < 0, neg_dir: sq_tag.dot_dir < 0,
                     fault: sq_tag.fault};
      // round to nearest: add half the divisor
      num_q[0]  <= (NumW'(mag_pan_q) << CosSh) + NumW'(den_pan_q >> 1);
      num_q[1]  <= (NumW'(mag_dir_q) << CosSh) + NumW'(den_dir_q >> 1);
      den2_q[0] <= den_pan_q;
      den2_q[1] <= den_dir_q;
      t2_tag_q  <= t1_tag_q;
    end
  end

  logic                 dv_valid;
  logic [1:0][QuoW-1:0] quo;
  sapg_dvtag_t          dv_tag;

  sapg_div #(
    .LANES (2),
    .NUM_W (NumW),
    .DEN_W (DenW),
    .QUO_W (QuoW),
    .TAG_W ($bits(sapg_dvtag_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t2_v_q),
    .num_i   (num_q),
    .den_i   (den2_q),
    .tag_i   (t2_tag_q),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .tag_o   (dv_tag)
  );

  // Pan, blend and gain
  logic        t3_v_q, t4_v_q, t5_v_q, t6_v_q, out_v_q;
  logic        f3_q, f4_q, f5_q, f6_q;
  logic [15:0] pan3_q, pan4_q, pan5_q, pan6_q, dir3_q, vol5_q, vol6_q;
  logic [31:0] lo_prod_q, hi_prod_q, g_prod_q;
  logic [32:0] vol_sum, g_sum;
  logic [17:0] vol_raw, g_raw;
  sapg_out_t   out_q;

  assign vol_sum = 33'(lo_prod_q) + 33'(hi_prod_q) + 33'(HalfQ15);
  assign vol_raw = vol_sum[32:15];
  assign g_sum   = 33'(g_prod_q) + 33'(HalfQ15);
  assign g_raw   = g_sum[32:15];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pan3_q    <= to_unit(dv_tag.neg_pan, quo[0]);
      dir3_q    <= to_unit(dv_tag.neg_dir, quo[1]);
      f3_q      <= dv_tag.fault;
      lo_prod_q <= 32'(min_level_q) * 32'(OneQ15 - dir3_q);
      hi_prod_q <= 32'(max_level_q) * 32'(dir3_q);
      pan4_q    <= pan3_q;
      f4_q      <= f3_q;
      vol5_q    <= (vol_raw > 18'(OneQ15)) ? OneQ15 : vol_raw[15:0];
      pan5_q    <= pan4_q;
      f5_q      <= f4_q;
      g_prod_q  <= 32'(pan5_q) * 32'(vol5_q);
      pan6_q    <= pan5_q;
      vol6_q    <= vol5_q;
      f6_q      <= f5_q;
      // zero every level on a degenerate vector
      out_q.gain         <= f6_q ? 16'd0 :
                            ((g_raw > 18'(OneQ15)) ? OneQ15 : g_raw[15:0]);
      out_q.pan_value    <= f6_q ? 16'd0 : pan6_q;
      out_q.volume_value <= f6_q ? 16'd0 : vol6_q;
      out_q.fault        <= f6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q  <= 1'b0;
      t2_v_q  <= 1'b0;
      t3_v_q  <= 1'b0;
      t4_v_q  <= 1'b0;
      t5_v_q  <= 1'b0;
      t6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      t1_v_q  <= sq_valid;
      t2_v_q  <= t1_v_q;
      t3_v_q  <= dv_valid;
      t4_v_q  <= t3_v_q;
      t5_v_q  <= t4_v_q;
      t6_v_q  <= t5_v_q;
      out_v_q <= t6_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Checks
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fault |->
      out_data_o.gain == 16'd0 && out_data_o.pan_value == 16'd0 &&
      out_data_o.volume_value == 16'd0)
    else $error("fault result carries nonzero levels");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pan_value <= OneQ15 &&
      out_data_o.volume_value <= OneQ15)
    else $error("pan or volume above unity");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gain <= out_data_o.pan_value &&
      out_data_o.gain <= out_data_o.volume_value)
    else $error("gain exceeds pan or volume");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while the pipe was held");

endmodule
